// ----- design/bgb_pkg.sv -----
// Shared types, constants and lookup functions of the Bayer grid brightness block.
// Standalone package: no dependencies. Used by bgb_cfg and the core in design/.
package bgb_pkg;

  // Fixed field and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 12;
  localparam int IDX_W     = 2 * POS_W + 1;

  // Geometry limits
  localparam logic [CFG_W-1:0] GEOM_MAX = 13'd4096;
  localparam logic [POS_W-1:0] ROW_MAX  = 12'd4095;

  // Parameter defaults
  localparam int GRID_ROWS_DEF  = 8;
  localparam int GRID_COLS_DEF  = 8;
  localparam int MAX_POINTS_DEF = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd2;

  // Colour of one byte inside a 2x2 cell
  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE,
    CH_NONE
  } bgb_chan_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_CELL,
    S_ADV,
    S_END,
    S_AVG,
    S_OUT
  } bgb_state_e;

  // Operations run on the shared divider
  typedef enum logic [3:0] {
    OP_LS,
    OP_CS,
    OP_NR,
    OP_NC,
    OP_Y0,
    OP_Y1,
    OP_X0,
    OP_X1,
    OP_R,
    OP_G,
    OP_B
  } bgb_op_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } bgb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] brightness;
    logic             no_samples;
  } bgb_out_t;

  // Register view handed from the config block to the core
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] start_offset;
    logic             geom_changed;
  } bgb_cfg_t;

  // Saturate frame geometry at 4096
  function automatic logic [CFG_W-1:0] clamp_geom(input logic [CFG_W-1:0] v);
    clamp_geom = (v > GEOM_MAX) ? GEOM_MAX : v;
  endfunction

  // Colour by cell parity {y[0], c[0]} and byte offset {dy, dx}
  function automatic bgb_chan_e chan_lookup(input logic [1:0] par, input logic [1:0] off);
    bgb_chan_e ch;
    ch = CH_NONE;
    case (par)
      2'd0: begin
        case (off)
          2'd0:    ch = CH_GREEN;
          2'd1:    ch = CH_BLUE;
          2'd2:    ch = CH_RED;
          default: ch = CH_NONE;
        endcase
      end
      2'd1: begin
        case (off)
          2'd0:    ch = CH_BLUE;
          2'd1:    ch = CH_GREEN;
          2'd3:    ch = CH_RED;
          default: ch = CH_NONE;
        endcase
      end
      2'd2: begin
        case (off)
          2'd0:    ch = CH_RED;
          2'd1:    ch = CH_GREEN;
          2'd3:    ch = CH_BLUE;
          default: ch = CH_NONE;
        endcase
      end
      default: begin
        case (off)
          2'd0:    ch = CH_GREEN;
          2'd1:    ch = CH_RED;
          2'd2:    ch = CH_BLUE;
          default: ch = CH_NONE;
        endcase
      end
    endcase
    chan_lookup = ch;
  endfunction

endpackage

// ----- design/bgb_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared by all divide steps of the core.
module bgb_div #(
  parameter int W = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers need no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- design/bgb_cfg.sv -----
// Configuration registers: frame width, frame height and start offset.
// Depends on bgb_pkg; presents clamped geometry to the core.
module bgb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bgb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bgb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          idle_i,
  output logic                          cfg_ready_o,
  output bgb_pkg::bgb_cfg_t             cfg_o
);

  logic [bgb_pkg::CFG_W-1:0] width_q, height_q, offset_q;
  logic                      wr;

  // Take writes only between items
  assign cfg_ready_o = idle_i;
  assign wr          = cfg_valid_i && idle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      offset_q <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        bgb_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        bgb_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        bgb_pkg::REG_START_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flag geometry writes so the core drops its cached grid steps
  always_comb begin
    cfg_o.width        = bgb_pkg::clamp_geom(width_q);
    cfg_o.height       = bgb_pkg::clamp_geom(height_q);
    cfg_o.start_offset = offset_q;
    cfg_o.geom_changed = wr && (cfg_index_i == bgb_pkg::REG_FRAME_WIDTH ||
                                cfg_index_i == bgb_pkg::REG_FRAME_HEIGHT);
  end

endmodule

// ----- design/bayer_grid_brightness_core.sv -----
// Top level of the Bayer grid brightness statistics block.
// Depends on bgb_pkg, bgb_div (shared divider) and bgb_cfg (register file).
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------
//  in      | sink      | in_valid_i/in_stall_o   | bgb_in_t  {pixel, frame_end}
//  out     | source    | out_valid_o/out_stall_i | bgb_out_t {brightness, no_samples}
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A pixel inside the skip offset is taken without a divide. Any other pixel runs four
// divides (row and column position by grid step) on the shared divider, fewer on row
// or column zero where a divide is skipped, none when a grid step is zero, then a cell
// update per byte offset and a position advance; no new pixel is taken meanwhile.
// After a width or height write, the next unskipped pixel first runs up to four more
// divides recomputing the grid; a frame_end pixel with samples adds three divides
// (channel means). Register writes are taken only while idle with no pixel offered.
// Reset is asynchronous, active low, and leaves all sums and positions
// cleared. A stalled result waits in the output register while the next pixels are
// taken; a second result then holds the sequencer until the first is taken.
module bayer_grid_brightness_core #(
  parameter int GRID_ROWS  = bgb_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = bgb_pkg::GRID_COLS_DEF,
  parameter int MAX_POINTS = bgb_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bgb_pkg::bgb_in_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bgb_pkg::bgb_out_t             out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bgb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bgb_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int POS_W  = bgb_pkg::POS_W;
  localparam int CFG_W  = bgb_pkg::CFG_W;
  localparam int PIX_W  = bgb_pkg::PIX_W;
  localparam int IDX_W  = bgb_pkg::IDX_W;
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = $clog2(255 * MAX_POINTS + 1);
  localparam int DW     = (SUM_W > CFG_W) ? SUM_W : CFG_W;
  localparam int TOT_W  = SUM_W + 2;
  // Truncated divide by three of any TOT_W-bit total: (x * ceil(2^(TOT_W+1)/3)) >> (TOT_W+1)
  localparam int RCP_SH = TOT_W + 1;
  localparam int RCP_W  = TOT_W;
  localparam logic [RCP_W-1:0] RCP3 = RCP_W'(((2 ** RCP_SH) + 2) / 3);
  localparam int PROD_W = TOT_W + RCP_W;

  bgb_pkg::bgb_cfg_t   cfg;
  bgb_pkg::bgb_state_e state_q, state_d;
  bgb_pkg::bgb_op_e    op_q, op_d;
  bgb_pkg::bgb_chan_e  cell_ch;
  bgb_pkg::bgb_out_t   res_q, res_d, out_q, out_d;

  logic [1:0]       d_q, d_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             last_q, last_d;
  logic             frame_open_q, frame_open_d;
  logic [CFG_W-1:0] skip_q, skip_d, eff_skip;
  logic [POS_W-1:0] row_q, row_d, col_q, col_d;
  logic [SUM_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic             geom_ok_q, geom_ok_d;
  logic [POS_W-1:0] ls_q, ls_d, cs_q, cs_d, nrows_q, nrows_d, ncols_q, ncols_d;
  logic [POS_W-1:0] qy_q [2], qy_d [2], qx_q [2], qx_d [2];
  logic [1:0]       rok_q, rok_d, cok_q, cok_d;
  logic [SUM_W-1:0] mr_q, mr_d, mg_q, mg_d, mb_q, mb_d;
  logic             out_valid_q, out_valid_d;

  logic             div_start, div_done;
  logic [DW-1:0]    div_dvd, div_dvs, div_quo, div_rem;
  logic [POS_W-1:0] qpos;
  logic             rem_zero;

  logic             dy, dx;
  logic [POS_W-1:0] qy_m1, qx_m1;
  logic [IDX_W-1:0] idx_full;
  logic             cell_hit;
  logic [CFG_W-1:0] col_inc;
  logic [TOT_W-1:0] tot;
  logic [PROD_W-1:0] prod;

  bgb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .idle_i      ((state_q == bgb_pkg::S_IDLE) && !in_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  bgb_div #(
    .W (DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign qpos     = div_quo[POS_W-1:0];
  assign rem_zero = (div_rem == '0);

  // Select divider operands for the current operation
  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    case (op_q)
      bgb_pkg::OP_LS: begin
        div_dvd = DW'(cfg.height);
        div_dvs = DW'(GRID_ROWS + 1);
      end
      bgb_pkg::OP_CS: begin
        div_dvd = DW'(cfg.width);
        div_dvs = DW'(GRID_COLS + 1);
      end
      bgb_pkg::OP_NR: begin
        div_dvd = DW'(cfg.height - 13'd1);
        div_dvs = DW'(ls_q);
      end
      bgb_pkg::OP_NC: begin
        div_dvd = DW'(cfg.width - 13'd1);
        div_dvs = DW'(cs_q);
      end
      bgb_pkg::OP_Y0: begin
        div_dvd = DW'(row_q);
        div_dvs = DW'(ls_q);
      end
      bgb_pkg::OP_Y1: begin
        div_dvd = DW'(row_q - 12'd1);
        div_dvs = DW'(ls_q);
      end
      bgb_pkg::OP_X0: begin
        div_dvd = DW'(col_q);
        div_dvs = DW'(cs_q);
      end
      bgb_pkg::OP_X1: begin
        div_dvd = DW'(col_q - 12'd1);
        div_dvs = DW'(cs_q);
      end
      bgb_pkg::OP_R: begin
        div_dvd = DW'(red_q);
        div_dvs = DW'(pcnt_q);
      end
      bgb_pkg::OP_G: begin
        div_dvd = DW'(green_q);
        div_dvs = DW'(pcnt_q);
      end
      bgb_pkg::OP_B: begin
        div_dvd = DW'(blue_q);
        div_dvs = DW'(pcnt_q);
      end
      default: ;
    endcase
  end

  // Cell check for the byte offset d_q: grid hit, point index and colour
  assign dy       = d_q[1];
  assign dx       = d_q[0];
  assign qy_m1    = qy_q[dy] - 12'd1;
  assign qx_m1    = qx_q[dx] - 12'd1;
  assign idx_full = IDX_W'(qy_m1) * IDX_W'(ncols_q) + IDX_W'(qx_m1);
  assign cell_hit = rok_q[dy] && cok_q[dx] && (idx_full < IDX_W'(MAX_POINTS));
  assign cell_ch  = bgb_pkg::chan_lookup({row_q[0] ^ dy, col_q[0] ^ dx}, d_q);

  assign eff_skip = frame_open_q ? skip_q : cfg.start_offset;
  assign col_inc  = CFG_W'(col_q) + 13'd1;
  assign tot      = TOT_W'(mr_q) + TOT_W'(mg_q) + TOT_W'(mb_q);
  assign prod     = PROD_W'(tot) * PROD_W'(RCP3);

  assign in_stall_o = (state_q != bgb_pkg::S_IDLE);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    d_d          = d_q;
    pix_d        = pix_q;
    last_d       = last_q;
    frame_open_d = frame_open_q;
    skip_d       = skip_q;
    row_d        = row_q;
    col_d        = col_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    pcnt_d       = pcnt_q;
    geom_ok_d    = geom_ok_q;
    ls_d         = ls_q;
    cs_d         = cs_q;
    nrows_d      = nrows_q;
    ncols_d      = ncols_q;
    qy_d         = qy_q;
    qx_d         = qx_q;
    rok_d        = rok_q;
    cok_d        = cok_q;
    mr_d         = mr_q;
    mg_d         = mg_q;
    mb_d         = mb_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    div_start    = 1'b0;

    // Drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bgb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          pix_d        = in_i.pixel;
          last_d       = in_i.frame_end;
          frame_open_d = 1'b1;
          if (eff_skip != '0) begin
            skip_d  = eff_skip - 13'd1;
            state_d = in_i.frame_end ? bgb_pkg::S_END : bgb_pkg::S_IDLE;
          end else begin
            skip_d = '0;
            if (!geom_ok_q) begin
              op_d    = bgb_pkg::OP_LS;
              state_d = bgb_pkg::S_ISSUE;
            end else if (ls_q == '0 || cs_q == '0) begin
              state_d = bgb_pkg::S_ADV;
            end else begin
              op_d    = bgb_pkg::OP_Y0;
              state_d = bgb_pkg::S_ISSUE;
            end
          end
        end
      end

      bgb_pkg::S_ISSUE: begin
        if (op_q == bgb_pkg::OP_Y1 && row_q == '0) begin
          // No row above: lower cell half cannot hit
          rok_d[1] = 1'b0;
          op_d     = bgb_pkg::OP_X0;
        end else if (op_q == bgb_pkg::OP_X1 && col_q == '0) begin
          cok_d[1] = 1'b0;
          d_d      = '0;
          state_d  = bgb_pkg::S_CELL;
        end else begin
          div_start = 1'b1;
          state_d   = bgb_pkg::S_WAIT;
        end
      end

      bgb_pkg::S_WAIT: begin
        if (div_done) begin
          state_d = bgb_pkg::S_ISSUE;
          case (op_q)
            bgb_pkg::OP_LS: begin
              ls_d = qpos;
              op_d = bgb_pkg::OP_CS;
            end
            bgb_pkg::OP_CS: begin
              cs_d = qpos;
              if (ls_q == '0 || qpos == '0) begin
                geom_ok_d = 1'b1;
                state_d   = bgb_pkg::S_ADV;
              end else begin
                op_d = bgb_pkg::OP_NR;
              end
            end
            bgb_pkg::OP_NR: begin
              nrows_d = (qpos != '0) ? qpos - 12'd1 : '0;
              op_d    = bgb_pkg::OP_NC;
            end
            bgb_pkg::OP_NC: begin
              ncols_d   = (qpos != '0) ? qpos - 12'd1 : '0;
              geom_ok_d = 1'b1;
              op_d      = bgb_pkg::OP_Y0;
            end
            bgb_pkg::OP_Y0: begin
              qy_d[0]  = qpos;
              rok_d[0] = rem_zero && qpos != '0 && qpos <= nrows_q;
              op_d     = bgb_pkg::OP_Y1;
            end
            bgb_pkg::OP_Y1: begin
              qy_d[1]  = qpos;
              rok_d[1] = rem_zero && qpos != '0 && qpos <= nrows_q;
              op_d     = bgb_pkg::OP_X0;
            end
            bgb_pkg::OP_X0: begin
              qx_d[0]  = qpos;
              cok_d[0] = rem_zero && qpos != '0 && qpos <= ncols_q;
              op_d     = bgb_pkg::OP_X1;
            end
            bgb_pkg::OP_X1: begin
              qx_d[1]  = qpos;
              cok_d[1] = rem_zero && qpos != '0 && qpos <= ncols_q;
              d_d      = '0;
              state_d  = bgb_pkg::S_CELL;
            end
            bgb_pkg::OP_R: begin
              mr_d = div_quo[SUM_W-1:0];
              op_d = bgb_pkg::OP_G;
            end
            bgb_pkg::OP_G: begin
              mg_d = div_quo[SUM_W-1:0];
              op_d = bgb_pkg::OP_B;
            end
            bgb_pkg::OP_B: begin
              mb_d    = div_quo[SUM_W-1:0];
              state_d = bgb_pkg::S_AVG;
            end
            default: state_d = bgb_pkg::S_IDLE;
          endcase
        end
      end

      bgb_pkg::S_CELL: begin
        // Add the byte to the channel of each cell it belongs to
        if (cell_hit) begin
          case (cell_ch)
            bgb_pkg::CH_RED:   red_d   = red_q + SUM_W'(pix_q);
            bgb_pkg::CH_GREEN: green_d = green_q + SUM_W'(pix_q);
            bgb_pkg::CH_BLUE:  blue_d  = blue_q + SUM_W'(pix_q);
            default: ;
          endcase
          if (d_q == 2'd0) begin
            pcnt_d = pcnt_q + PCNT_W'(1);
          end
        end
        if (d_q == 2'd3) begin
          state_d = bgb_pkg::S_ADV;
        end else begin
          d_d = d_q + 2'd1;
        end
      end

      bgb_pkg::S_ADV: begin
        // Advance column, wrap to next row, hold row at its ceiling
        if (col_inc >= cfg.width) begin
          col_d = '0;
          if (row_q != bgb_pkg::ROW_MAX) begin
            row_d = row_q + 12'd1;
          end
        end else begin
          col_d = col_inc[POS_W-1:0];
        end
        state_d = last_q ? bgb_pkg::S_END : bgb_pkg::S_IDLE;
      end

      bgb_pkg::S_END: begin
        if (pcnt_q == '0) begin
          res_d.brightness = '0;
          res_d.no_samples = 1'b1;
          state_d          = bgb_pkg::S_OUT;
        end else begin
          op_d    = bgb_pkg::OP_R;
          state_d = bgb_pkg::S_ISSUE;
        end
      end

      bgb_pkg::S_AVG: begin
        res_d.brightness = prod[RCP_SH +: PIX_W];
        res_d.no_samples = 1'b0;
        state_d          = bgb_pkg::S_OUT;
      end

      bgb_pkg::S_OUT: begin
        // Load the result once the output register is free, then open a new frame
        if (!out_valid_q || !out_stall_i) begin
          out_d        = res_q;
          out_valid_d  = 1'b1;
          frame_open_d = 1'b0;
          skip_d       = '0;
          row_d        = '0;
          col_d        = '0;
          red_d        = '0;
          green_d      = '0;
          blue_d       = '0;
          pcnt_d       = '0;
          state_d      = bgb_pkg::S_IDLE;
        end
      end

      default: state_d = bgb_pkg::S_IDLE;
    endcase

    // A width or height write invalidates the cached grid
    if (cfg.geom_changed) begin
      geom_ok_d = 1'b0;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= bgb_pkg::OP_LS;
      d_q          <= '0;
      frame_open_q <= 1'b0;
      skip_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
      red_q        <= '0;
      green_q      <= '0;
      blue_q       <= '0;
      pcnt_q       <= '0;
      geom_ok_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      op_q         <= op_d;
      d_q          <= d_d;
      frame_open_q <= frame_open_d;
      skip_q       <= skip_d;
      row_q        <= row_d;
      col_q        <= col_d;
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      pcnt_q       <= pcnt_d;
      geom_ok_q    <= geom_ok_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and cached values
  always_ff @(posedge clk_i) begin
    pix_q   <= pix_d;
    last_q  <= last_d;
    ls_q    <= ls_d;
    cs_q    <= cs_d;
    nrows_q <= nrows_d;
    ncols_q <= ncols_d;
    qy_q    <= qy_d;
    qx_q    <= qx_d;
    rok_q   <= rok_d;
    cok_q   <= cok_d;
    mr_q    <= mr_d;
    mg_q    <= mg_d;
    mb_q    <= mb_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_pcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= PCNT_W'(MAX_POINTS))
    else $error("point count above MAX_POINTS");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bgb_pkg::S_WAIT)
    else $error("divider finished outside the wait state");

  a_cell_geom_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bgb_pkg::S_CELL |-> geom_ok_q && ls_q != '0 && cs_q != '0)
    else $error("cell update without a valid grid");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.no_samples |-> out_o.brightness == '0)
    else $error("empty frame gave nonzero brightness");
`endif

endmodule

// ----- test/bayer_grid_brightness_core_tb.sv -----
// Self-checking testbench for bayer_grid_brightness_core: pixel frames in, one brightness
// word per frame out, predicted by a scoreboard class and compared field by field.
// Depends on bgb_pkg and the design/ sources only.
module bayer_grid_brightness_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 500;
  localparam int HOLD_CYCLES  = 2500;
  localparam int STALL_LIMIT  = 20000;
  localparam int ITEM_TARGET  = 1800;
  localparam int FRAME_TARGET = 40;

  // Frame statistics predictor plus the queue of brightness words still owed
  class brightness_scoreboard;
    logic [bgb_pkg::CFG_W-1:0] width_reg;
    logic [bgb_pkg::CFG_W-1:0] height_reg;
    logic [bgb_pkg::CFG_W-1:0] offset_reg;
    int unsigned               skip_left, row_pos, col_pos;
    int unsigned               red_sum, green_sum, blue_sum, point_count;
    bit                        frame_open;
    bgb_pkg::bgb_chan_e        cell_colour [4][4];
    bgb_pkg::bgb_out_t         expected_q[$];
    int unsigned               frames_closed;
    int unsigned               mismatches;

    function new();
      // colour by {y[0], c[0]} and byte offset {dy, dx} inside the cell
      cell_colour = '{'{bgb_pkg::CH_GREEN, bgb_pkg::CH_BLUE, bgb_pkg::CH_RED,
                        bgb_pkg::CH_NONE},
                      '{bgb_pkg::CH_BLUE, bgb_pkg::CH_GREEN, bgb_pkg::CH_NONE,
                        bgb_pkg::CH_RED},
                      '{bgb_pkg::CH_RED, bgb_pkg::CH_GREEN, bgb_pkg::CH_NONE,
                        bgb_pkg::CH_BLUE},
                      '{bgb_pkg::CH_GREEN, bgb_pkg::CH_RED, bgb_pkg::CH_BLUE,
                        bgb_pkg::CH_NONE}};
      width_reg     = 13'd640;
      height_reg    = 13'd480;
      offset_reg    = '0;
      frames_closed = 0;
      mismatches    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      skip_left   = 0;
      row_pos     = 0;
      col_pos     = 0;
      red_sum     = 0;
      green_sum   = 0;
      blue_sum    = 0;
      point_count = 0;
      frame_open  = 1'b0;
    endfunction

    function int unsigned limit_geom(logic [bgb_pkg::CFG_W-1:0] v);
      return (v > bgb_pkg::GEOM_MAX) ? 32'(bgb_pkg::GEOM_MAX) : 32'(v);
    endfunction

    function void write_reg(logic [bgb_pkg::CFG_IDX_W-1:0] idx,
                            logic [bgb_pkg::CFG_W-1:0] val);
      case (idx)
        bgb_pkg::REG_FRAME_WIDTH:  width_reg = val;
        bgb_pkg::REG_FRAME_HEIGHT: height_reg = val;
        bgb_pkg::REG_START_OFFSET: offset_reg = val;
        default: ;
      endcase
    endfunction

    // Add one byte to every grid cell that covers the current position
    function void accumulate(logic [bgb_pkg::PIX_W-1:0] px);
      int unsigned        wd, ht, ls, cs, nrows, ncols, yb, cb, ki, kj, idx, dy, dx;
      bgb_pkg::bgb_chan_e ch;
      wd = limit_geom(width_reg);
      ht = limit_geom(height_reg);
      ls = ht / (bgb_pkg::GRID_ROWS_DEF + 1);
      cs = wd / (bgb_pkg::GRID_COLS_DEF + 1);
      if (ls == 0 || cs == 0) return;
      nrows = ((ht - 1) / ls >= 1) ? (ht - 1) / ls - 1 : 0;
      ncols = ((wd - 1) / cs >= 1) ? (wd - 1) / cs - 1 : 0;
      for (int d = 0; d < 4; d++) begin
        dy = d / 2;
        dx = d % 2;
        if (row_pos < dy || col_pos < dx) continue;
        yb = row_pos - dy;
        cb = col_pos - dx;
        if (yb % ls != 0 || cb % cs != 0) continue;
        ki = yb / ls;
        kj = cb / cs;
        if (ki < 1 || ki > nrows || kj < 1 || kj > ncols) continue;
        idx = (ki - 1) * ncols + (kj - 1);
        if (idx >= bgb_pkg::MAX_POINTS_DEF) continue;
        ch = cell_colour[{yb[0], cb[0]}][d];
        case (ch)
          bgb_pkg::CH_RED:   red_sum += 32'(px);
          bgb_pkg::CH_GREEN: green_sum += 32'(px);
          bgb_pkg::CH_BLUE:  blue_sum += 32'(px);
          default: ;
        endcase
        if (d == 0) point_count++;
      end
    endfunction

    // Advance the frame by one accepted pixel word; close it on frame_end
    function void note_pixel(bgb_pkg::bgb_in_t w);
      int unsigned       r, g, b;
      bgb_pkg::bgb_out_t res;
      if (!frame_open) begin
        frame_open = 1'b1;
        skip_left  = 32'(offset_reg);
      end
      if (skip_left > 0) begin
        skip_left--;
      end else begin
        accumulate(w.pixel);
        col_pos++;
        if (col_pos >= limit_geom(width_reg)) begin
          col_pos = 0;
          if (row_pos < bgb_pkg::ROW_MAX) row_pos++;
        end
      end
      if (!w.frame_end) return;
      if (point_count == 0) begin
        res.brightness = '0;
        res.no_samples = 1'b1;
      end else begin
        r = red_sum / point_count;
        g = green_sum / point_count;
        b = blue_sum / point_count;
        res.brightness = 8'((r + g + b) / 3);
        res.no_samples = 1'b0;
      end
      expected_q.push_back(res);
      frames_closed++;
      clear_frame();
    endfunction

    function void check_result(bgb_pkg::bgb_out_t got);
      bgb_pkg::bgb_out_t want;
      if (expected_q.size() == 0) begin
        $error("result word with none pending: brightness %0d no_samples %0d",
               got.brightness, got.no_samples);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.brightness !== want.brightness) begin
        $error("brightness: expected %0d, got %0d", want.brightness, got.brightness);
        mismatches++;
      end
      if (got.no_samples !== want.no_samples) begin
        $error("no_samples: expected %0d, got %0d", want.no_samples, got.no_samples);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  bgb_pkg::bgb_in_t              in_i        = '0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  bgb_pkg::bgb_out_t             out_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [bgb_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bgb_pkg::CFG_W-1:0]     cfg_data_i  = '0;

  brightness_scoreboard sb = new();
  int unsigned          pixels_sent = 0;
  int unsigned          idle_cycles = 0;
  bit                   tx_calm     = 1'b0;
  bit                   rx_calm     = 1'b0;
  bit                   hold_req    = 1'b0;

  bayer_grid_brightness_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Sample every handshake at the edge and feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        sb.note_pixel(in_i);
        pixels_sent <= pixels_sent + 1;
      end
      if (out_valid_o && !out_stall_i) sb.check_result(out_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // Drive the result stall: random runs, quiet stretches, one long hold-off on request
  initial begin : receiver
    int unsigned stall_left, r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rx_calm) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one pixel word and hold it until taken; valid stays high afterward
  task automatic send_word(input logic [bgb_pkg::PIX_W-1:0] px, input logic last);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= '{pixel: px, frame_end: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Send a frame of len words, the last one flagged as frame end
  task automatic send_frame(input int unsigned len, input int unsigned shade);
    logic [bgb_pkg::PIX_W-1:0] px;
    for (int unsigned i = 0; i < len; i++) begin
      case (shade)
        5:       px = 8'hFF;
        6:       px = 8'h00;
        7:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: px = bgb_pkg::PIX_W'($urandom_range(0, 255));
      endcase
      send_word(px, i == len - 1);
    end
  endtask

  task automatic program_reg(input logic [bgb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bgb_pkg::CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input int unsigned wd, input int unsigned ht,
                           input int unsigned off);
    program_reg(bgb_pkg::REG_FRAME_WIDTH, bgb_pkg::CFG_W'(wd));
    program_reg(bgb_pkg::REG_FRAME_HEIGHT, bgb_pkg::CFG_W'(ht));
    program_reg(bgb_pkg::REG_START_OFFSET, bgb_pkg::CFG_W'(off));
    cfg_valid_i <= 1'b0;
  endtask

  // Hold input until every owed word is back, then let the core settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned wd, ht, off, wc, hc, full, len, kind, nframes;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: a short frame that never reaches a grid point
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b1);
    drain();

    // Smallest geometry: grid step is zero
    configure(2, 2, 0);
    send_frame(4, 7);
    drain();

    // Oversized geometry, frames that end while still skipping
    configure(8191, 8191, 8191);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h33, 1'b1);
    drain();

    // Unit step with overlapping cells, frame cut in the middle of a cell
    configure(9, 9, 1);
    send_frame(14, 0);
    drain();

    // Back up results behind a long receiver hold-off
    configure(9, 9, 0);
    tx_calm  = 1'b1;
    hold_req = 1'b1;
    repeat (4) send_frame(2, 0);
    drain();
    tx_calm = 1'b0;

    // Random phases: new geometry, a few frames, then drain
    while (pixels_sent < ITEM_TARGET || sb.frames_closed < FRAME_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        wd  = $urandom_range(9, 20);
        ht  = $urandom_range(9, 20);
        off = $urandom_range(0, 3) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      end else if (kind < 72) begin
        wd  = $urandom_range(2, 20);
        ht  = $urandom_range(2, 8);
        off = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) begin
          ht = wd;
          wd = $urandom_range(2, 8);
        end
      end else if (kind < 86) begin
        wd  = $urandom_range(21, 8191);
        ht  = $urandom_range(9, 8191);
        off = $urandom_range(0, 3);
      end else begin
        wd  = $urandom_range(9, 20);
        ht  = $urandom_range(9, 20);
        off = $urandom_range(100, 8191);
      end
      configure(wd, ht, off);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      wc      = (wd > 4096) ? 4096 : wd;
      hc      = (ht > 4096) ? 4096 : ht;
      full    = off + wc * hc;
      nframes = $urandom_range(1, 4);
      for (int unsigned f = 0; f < nframes; f++) begin
        kind = $urandom_range(0, 99);
        if (kind < 40 && full <= 400) begin
          len = full;
        end else if (kind < 50 && full <= 400) begin
          // run past the last line
          len = full + $urandom_range(1, 2 * wc);
        end else begin
          len = $urandom_range(1, (full < 60) ? full : 60);
        end
        send_frame(len, $urandom_range(0, 7));
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
